// ===== sv/kem_pkg.sv =====
// kem_pkg: shared types and constants for the keyword elimination matcher.
// Used by the channel interfaces, the register block and the top level.
package kem_pkg;

  localparam int NUM_NAMES      = 4;
  localparam int MAX_NAME_LEN   = 4;
  localparam int CHARS_PER_WORD = 4;
  localparam int CHAR_W         = 16;
  localparam int WORD_W         = CHAR_W * CHARS_PER_WORD;
  localparam int LEN_W          = 3;
  localparam int CNT_W          = 3;
  localparam int POS_W          = 3;
  localparam int CIDX_W         = $clog2(CHARS_PER_WORD);
  localparam int KIND_W         = 4;
  localparam int VERDICT_W      = 2;
  localparam int PDATA_W        = 64;
  localparam int PADDR_W        = 6;
  localparam int RIDX_W         = 3;
  localparam int RIDX_LSB       = 3;

  // Register indexes (byte address = 8 * index)
  typedef enum logic [RIDX_W-1:0] {
    REG_NAME_COUNT   = 3'd0,
    REG_NAME_WORD_0  = 3'd1,
    REG_NAME_WORD_1  = 3'd2,
    REG_NAME_WORD_2  = 3'd3,
    REG_NAME_WORD_3  = 3'd4,
    REG_NAME_LENGTHS = 3'd5,
    REG_MATCH_KIND   = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_CHECK   = 4'b0001,
    PH_PENDING = 4'b0010,
    PH_GOOD    = 4'b0100,
    PH_FAIL    = 4'b1000
  } phase_t;

  // input action codes
  localparam logic ACT_FEED    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [VERDICT_W-1:0] V_EMPTY = 2'd0;
  localparam logic [VERDICT_W-1:0] V_BAD   = 2'd1;
  localparam logic [VERDICT_W-1:0] V_GOOD  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]                   name_count;
    logic [NUM_NAMES-1:0][WORD_W-1:0]   name_word;
    logic [NUM_NAMES*LEN_W-1:0]         name_lengths;
    logic [KIND_W-1:0]                  match_kind;
  } cfg_t;

endpackage

// ===== sv/kem_if.sv =====
// kem_in_if / kem_out_if: valid/ready channels for characters and verdicts.
// Depends on kem_pkg for field widths.
interface kem_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [kem_pkg::CHAR_W-1:0]   char_code;

  modport source (output valid, action, char_code, input ready);
  modport sink   (input valid, action, char_code, output ready);
endinterface

interface kem_out_if;
  logic                           valid;
  logic                           ready;
  logic [kem_pkg::VERDICT_W-1:0]  verdict;
  logic [kem_pkg::KIND_W-1:0]     kind;

  modport source (output valid, verdict, kind, input ready);
  modport sink   (input valid, verdict, kind, output ready);
endinterface

// ===== sv/kem_regs.sv =====
// kem_regs: APB-style configuration register file of the matcher.
// Depends on kem_pkg (cfg_t, register indexes).
module kem_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kem_pkg::PADDR_W-1:0]   paddr,
  input  logic [kem_pkg::PDATA_W-1:0]   pwdata,
  output logic [kem_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output kem_pkg::cfg_t                 cfg
);

  kem_pkg::cfg_t     cfg_r;
  kem_pkg::reg_idx_t ridx;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign ridx   = kem_pkg::reg_idx_t'(paddr[kem_pkg::RIDX_LSB +: kem_pkg::RIDX_W]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.name_count   <= kem_pkg::CNT_W'(1);
      cfg_r.name_word    <= '0;
      cfg_r.name_lengths <= '0;
      cfg_r.match_kind   <= '0;
    end else if (wr) begin
      unique case (ridx)
        kem_pkg::REG_NAME_COUNT:   cfg_r.name_count <= pwdata[kem_pkg::CNT_W-1:0];
        kem_pkg::REG_NAME_WORD_0:  cfg_r.name_word[0] <= pwdata[kem_pkg::WORD_W-1:0];
        kem_pkg::REG_NAME_WORD_1:  cfg_r.name_word[1] <= pwdata[kem_pkg::WORD_W-1:0];
        kem_pkg::REG_NAME_WORD_2:  cfg_r.name_word[2] <= pwdata[kem_pkg::WORD_W-1:0];
        kem_pkg::REG_NAME_WORD_3:  cfg_r.name_word[3] <= pwdata[kem_pkg::WORD_W-1:0];
        kem_pkg::REG_NAME_LENGTHS:
          cfg_r.name_lengths <= pwdata[kem_pkg::NUM_NAMES*kem_pkg::LEN_W-1:0];
        kem_pkg::REG_MATCH_KIND:   cfg_r.match_kind <= pwdata[kem_pkg::KIND_W-1:0];
        default: ;  // unmapped address: write dropped
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ridx)
      kem_pkg::REG_NAME_COUNT:   prdata = kem_pkg::PDATA_W'(cfg_r.name_count);
      kem_pkg::REG_NAME_WORD_0:  prdata = kem_pkg::PDATA_W'(cfg_r.name_word[0]);
      kem_pkg::REG_NAME_WORD_1:  prdata = kem_pkg::PDATA_W'(cfg_r.name_word[1]);
      kem_pkg::REG_NAME_WORD_2:  prdata = kem_pkg::PDATA_W'(cfg_r.name_word[2]);
      kem_pkg::REG_NAME_WORD_3:  prdata = kem_pkg::PDATA_W'(cfg_r.name_word[3]);
      kem_pkg::REG_NAME_LENGTHS: prdata = kem_pkg::PDATA_W'(cfg_r.name_lengths);
      kem_pkg::REG_MATCH_KIND:   prdata = kem_pkg::PDATA_W'(cfg_r.match_kind);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== sv/keyword_elimination_matcher_unit.sv =====
// keyword_elimination_matcher_unit: top level of the keyword matcher.
// Depends on kem_pkg, kem_if.sv (channel interfaces) and kem_regs.
//
// Usage:
//  - in_ch carries one beat per character: action=0 feeds char_code,
//    action=1 restarts matching (keywords and kind registers are kept).
//  - out_ch returns exactly one beat per input beat: verdict (0 empty or
//    pending, 1 bad, 2 recognized) and kind (match_kind on recognized, else 0).
//  - Configuration goes through the APB-style port: 64-bit registers at
//    byte address 8*i (name_count, name_word_0..3, name_lengths, match_kind).
//    pready is tied high; write only while no beat is in flight.
// Timing:
//  - The verdict of a beat is registered: it is loaded into the output register at the
//    edge that accepts the beat. One beat per cycle is sustained while out_ch.ready
//    is high; the candidate compare and the phase update sit between the matcher
//    state registers and the output register.
//  - The output register doubles as the skid point: in_ch.ready is high while
//    that register is empty or being drained in the same cycle, so a stalled
//    receiver holds one result and back-pressures the input after that.
// Reset (rst_n low, synchronous): phase checking, all candidates alive,
//  position zero, verdict empty, no output beat pending, registers at their
//  defaults (one name in use, zero words and lengths, kind zero).
module keyword_elimination_matcher_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  kem_in_if.sink                        in_ch,
  kem_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kem_pkg::PADDR_W-1:0]   paddr,
  input  logic [kem_pkg::PDATA_W-1:0]   pwdata,
  output logic [kem_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int N = kem_pkg::NUM_NAMES;

  kem_pkg::cfg_t cfg;

  // matcher state
  kem_pkg::phase_t                  phase_r, phase_nxt;
  logic [N-1:0]                     alive_r, alive_nxt;
  logic [kem_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [kem_pkg::VERDICT_W-1:0]    held_r, held_nxt;

  // output register
  logic                             out_valid_r;
  logic [kem_pkg::VERDICT_W-1:0]    out_verdict_r;
  logic [kem_pkg::KIND_W-1:0]       out_kind_r;

  logic                             acc;
  logic [kem_pkg::CNT_W-1:0]        used;
  logic [N-1:0]                     in_use;
  logic [N-1:0]                     keep;      // in use, alive, within length and char matches
  logic [N-1:0]                     complete;  // last char of that entry is now
  logic [kem_pkg::LEN_W-1:0]        len   [N];
  logic [kem_pkg::CNT_W-1:0]        hit_cnt;
  logic [kem_pkg::KIND_W-1:0]       kind_nxt;

  kem_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready   = !out_valid_r || out_ch.ready;
  assign acc           = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.verdict = out_verdict_r;
  assign out_ch.kind   = out_kind_r;

  // entries in use: zero counts as one, clipped to the number of slots
  always_comb begin
    if (cfg.name_count == '0)
      used = kem_pkg::CNT_W'(1);
    else if (cfg.name_count > kem_pkg::CNT_W'(N))
      used = kem_pkg::CNT_W'(N);
    else
      used = cfg.name_count;
  end

  // per-candidate compare, all entries in parallel
  always_comb begin
    for (int i = 0; i < N; i++) begin
      len[i] = cfg.name_lengths[kem_pkg::LEN_W*i +: kem_pkg::LEN_W];
      if (len[i] > kem_pkg::LEN_W'(kem_pkg::MAX_NAME_LEN))
        len[i] = kem_pkg::LEN_W'(kem_pkg::MAX_NAME_LEN);
      if (len[i] > kem_pkg::LEN_W'(kem_pkg::CHARS_PER_WORD))
        len[i] = kem_pkg::LEN_W'(kem_pkg::CHARS_PER_WORD);
      in_use[i] = kem_pkg::CNT_W'(i) < used;
      // a short entry (position past its length) is dropped, never read
      keep[i] = in_use[i] && alive_r[i] && ({1'b0, pos_r} < {1'b0, len[i]}) &&
                (cfg.name_word[i][kem_pkg::CHAR_W*pos_r[kem_pkg::CIDX_W-1:0]
                                   +: kem_pkg::CHAR_W] == in_ch.char_code);
      complete[i] = ({1'b0, pos_r} + 4'd1) == {1'b0, len[i]};
    end
  end

  assign hit_cnt = kem_pkg::CNT_W'($countones(keep));

  always_comb begin
    phase_nxt = phase_r;
    alive_nxt = alive_r;
    pos_nxt   = pos_r;
    held_nxt  = held_r;
    if (in_ch.action == kem_pkg::ACT_RESTART) begin
      phase_nxt = kem_pkg::PH_CHECK;
      alive_nxt = '1;
      pos_nxt   = '0;
      held_nxt  = kem_pkg::V_EMPTY;
    end else begin
      unique case (phase_r)
        kem_pkg::PH_CHECK: begin
          alive_nxt = (alive_r & ~in_use) | keep;
          if (hit_cnt == kem_pkg::CNT_W'(1)) begin
            if (|(keep & complete)) phase_nxt = kem_pkg::PH_PENDING;
          end else if (hit_cnt == '0) begin
            phase_nxt = kem_pkg::PH_FAIL;
            held_nxt  = kem_pkg::V_BAD;
          end
          if (pos_r != '1) pos_nxt = pos_r + kem_pkg::POS_W'(1);
        end
        kem_pkg::PH_PENDING: begin
          phase_nxt = kem_pkg::PH_GOOD;
          held_nxt  = kem_pkg::V_GOOD;
        end
        kem_pkg::PH_GOOD: begin
          phase_nxt = kem_pkg::PH_FAIL;
          held_nxt  = kem_pkg::V_BAD;
        end
        kem_pkg::PH_FAIL: ;  // sticky until restart
        default: ;
      endcase
    end
    kind_nxt = (held_nxt == kem_pkg::V_GOOD) ? cfg.match_kind : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= kem_pkg::PH_CHECK;
      alive_r     <= '1;
      pos_r       <= '0;
      held_r      <= kem_pkg::V_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        phase_r     <= phase_nxt;
        alive_r     <= alive_nxt;
        pos_r       <= pos_nxt;
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (acc) begin
      out_verdict_r <= held_nxt;
      out_kind_r    <= kind_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_fail_is_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == kem_pkg::PH_FAIL) |-> (held_r == kem_pkg::V_BAD))
    else $error("failed phase without bad verdict");

  a_good_is_good: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == kem_pkg::PH_GOOD) |-> (held_r == kem_pkg::V_GOOD))
    else $error("good phase without recognized verdict");

  a_restart_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.action == kem_pkg::ACT_RESTART) |=>
      (out_valid_r && out_verdict_r == kem_pkg::V_EMPTY && out_kind_r == '0 &&
       phase_r == kem_pkg::PH_CHECK && pos_r == '0))
    else $error("restart did not clear matcher state");

  a_kind_only_on_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r != kem_pkg::V_GOOD) |-> (out_kind_r == '0))
    else $error("nonzero kind without recognized verdict");

endmodule

// ===== tb/sv/kem_verdict_checker.sv =====
// kem_verdict_checker: watches the character, verdict and register ports of the
// keyword matcher, predicts each verdict beat and compares it field by field.
// Depends on kem_pkg for widths, register indexes, phase codes and verdicts.
module kem_verdict_checker
  import kem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_action,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [VERDICT_W-1:0] out_verdict,
  input  logic [KIND_W-1:0]    out_kind,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic                 cfg_pready,
  input  logic [PADDR_W-1:0]   cfg_paddr,
  input  logic [PDATA_W-1:0]   cfg_pwdata,
  output int                   error_count,
  output int                   pending_count,
  output int                   match_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [KIND_W-1:0]    kind;
  } verdict_beat_t;

  // register shadow
  logic [CNT_W-1:0]            sh_count;
  logic [WORD_W-1:0]           sh_word [NUM_NAMES];
  logic [NUM_NAMES*LEN_W-1:0]  sh_lengths;
  logic [KIND_W-1:0]           sh_kind;

  // matcher state
  phase_t                      mt_phase;
  logic [NUM_NAMES-1:0]        mt_alive;
  logic [POS_W-1:0]            mt_pos;
  logic [VERDICT_W-1:0]        mt_held;

  verdict_beat_t               expected_verdicts[$];
  int                          errs;
  int                          recognized;

  function automatic int live_entries();
    int n;
    n = int'(sh_count);
    if (n == 0) n = 1;
    if (n > NUM_NAMES) n = NUM_NAMES;
    return n;
  endfunction

  function automatic int keyword_len(int i);
    int l;
    l = int'(sh_lengths[LEN_W*i +: LEN_W]);
    if (l > MAX_NAME_LEN) l = MAX_NAME_LEN;
    if (l > CHARS_PER_WORD) l = CHARS_PER_WORD;
    return l;
  endfunction

  function automatic void restart_match();
    mt_phase = PH_CHECK;
    mt_alive = '1;
    mt_pos   = '0;
    mt_held  = V_EMPTY;
  endfunction

  function automatic verdict_beat_t predict_verdict(logic act, logic [CHAR_W-1:0] ch);
    verdict_beat_t r;
    int used;
    int hits;
    int last;
    int pos;
    bit drop;
    r.verdict = V_EMPTY;
    r.kind    = '0;
    if (act == ACT_RESTART) begin
      restart_match();
      return r;
    end
    case (mt_phase)
      PH_CHECK: begin
        used = live_entries();
        hits = 0;
        last = 0;
        pos  = int'(mt_pos);
        for (int i = 0; i < NUM_NAMES; i++) begin
          if (i < used && mt_alive[i]) begin
            // too short to have a character here counts as a miss
            drop = (pos >= keyword_len(i));
            if (!drop) drop = (sh_word[i][CHAR_W*pos +: CHAR_W] != ch);
            if (drop) mt_alive[i] = 1'b0;
            else begin
              hits++;
              last = i;
            end
          end
        end
        if (hits == 1) begin
          if (pos + 1 == keyword_len(last)) mt_phase = PH_PENDING;
        end else if (hits == 0) begin
          mt_phase = PH_FAIL;
          mt_held  = V_BAD;
        end
        if (mt_pos != '1) mt_pos = mt_pos + 1'b1;
      end
      PH_PENDING: begin
        mt_phase = PH_GOOD;
        mt_held  = V_GOOD;
      end
      PH_GOOD: begin
        mt_phase = PH_FAIL;
        mt_held  = V_BAD;
      end
      default: ;
    endcase
    r.verdict = mt_held;
    if (mt_held == V_GOOD) r.kind = sh_kind;
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_beat_t want;
    if (!rst_n) begin
      sh_count   = CNT_W'(1);
      for (int i = 0; i < NUM_NAMES; i++) sh_word[i] = '0;
      sh_lengths = '0;
      sh_kind    = '0;
      restart_match();
      expected_verdicts.delete();
      errs       = 0;
      recognized = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[PADDR_W-1:RIDX_LSB]))
          REG_NAME_COUNT:   sh_count   = cfg_pwdata[CNT_W-1:0];
          REG_NAME_WORD_0:  sh_word[0] = cfg_pwdata[WORD_W-1:0];
          REG_NAME_WORD_1:  sh_word[1] = cfg_pwdata[WORD_W-1:0];
          REG_NAME_WORD_2:  sh_word[2] = cfg_pwdata[WORD_W-1:0];
          REG_NAME_WORD_3:  sh_word[3] = cfg_pwdata[WORD_W-1:0];
          REG_NAME_LENGTHS: sh_lengths = cfg_pwdata[NUM_NAMES*LEN_W-1:0];
          REG_MATCH_KIND:   sh_kind    = cfg_pwdata[KIND_W-1:0];
          default: ;
        endcase
      end
      // result beats belong to earlier inputs, so drain before predicting
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          if (errs < 10)
            $display("[%0t] unexpected verdict beat: verdict %0d kind %0d",
                     $realtime, out_verdict, out_kind);
          errs++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_verdict != want.verdict || out_kind != want.kind) begin
            if (errs < 10)
              $display("[%0t] verdict mismatch: expected verdict %0d kind %0d, got %0d %0d",
                       $realtime, want.verdict, want.kind, out_verdict, out_kind);
            errs++;
          end
          if (out_verdict == V_GOOD) recognized++;
        end
      end
      if (in_valid && in_ready)
        expected_verdicts.insert(expected_verdicts.size(),
                                 predict_verdict(in_action, in_char_code));
    end
    error_count   <= errs;
    pending_count <= expected_verdicts.size();
    match_count   <= recognized;
  end

endmodule

// ===== tb/sv/tb_keyword_elimination_matcher_unit.sv =====
// tb_keyword_elimination_matcher_unit: stimulus and verdict for the keyword matcher.
// Drives characters and register writes; kem_verdict_checker does the prediction.
// Depends on kem_pkg, kem_if.sv, the matcher RTL and kem_verdict_checker.
module tb_keyword_elimination_matcher_unit;
  import kem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PHASES   = 8;
  localparam int BEATS_PER_PHASE = 62;   // ~520 random beats overall
  localparam int ALPHA_SIZE      = 6;

  // ---------------------------------------------------------------------------
  // clock, reset and every block input start from a known value
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  kem_in_if  in_if ();
  kem_out_if out_if ();

  logic                 in_valid_r  = 1'b0;
  logic                 in_action_r = 1'b0;
  logic [CHAR_W-1:0]    in_char_r   = '0;
  logic                 rx_ready    = 1'b0;

  assign in_if.valid     = in_valid_r;
  assign in_if.action    = in_action_r;
  assign in_if.char_code = in_char_r;
  assign out_if.ready    = rx_ready;

  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]   pwdata  = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  keyword_elimination_matcher_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  int chk_errors;
  int chk_pending;
  int chk_matches;

  kem_verdict_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_action     (in_if.action),
    .in_char_code  (in_if.char_code),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_verdict   (out_if.verdict),
    .out_kind      (out_if.kind),
    .cfg_psel      (psel),
    .cfg_penable   (penable),
    .cfg_pwrite    (pwrite),
    .cfg_pready    (pready),
    .cfg_paddr     (paddr),
    .cfg_pwdata    (pwdata),
    .error_count   (chk_errors),
    .pending_count (chk_pending),
    .match_count   (chk_matches)
  );

  // ---------------------------------------------------------------------------
  // receiver: switches between always-ready, random and long-stall modes so
  // that back-pressure hits every phase of the matcher, with clean stretches
  // ---------------------------------------------------------------------------
  int rx_mode  = 0;
  int rx_left  = 0;
  int rx_stall = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(16, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: rx_ready <= 1'b1;
      1: rx_ready <= ($urandom_range(0, 9) < 7);
      default: begin
        if (rx_stall != 0) begin
          rx_ready <= 1'b0;
          rx_stall <= rx_stall - 1;
        end else begin
          rx_ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) rx_stall <= $urandom_range(1, 10);
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // stimulus state
  // ---------------------------------------------------------------------------
  int                 burst_left = 0;
  int                 beats_sent = 0;
  int                 settings_applied = 0;

  logic [CNT_W-1:0]   kw_count;
  logic [WORD_W-1:0]  kw_word [NUM_NAMES];
  logic [LEN_W-1:0]   kw_len  [NUM_NAMES];
  logic [KIND_W-1:0]  kw_kind;
  logic [CHAR_W-1:0]  alphabet [ALPHA_SIZE];

  // One character beat. Entered at a falling edge, leaves at a falling edge.
  // valid only drops when a gap is taken, so it never toggles within a step.
  task automatic send_beat(input logic act, input logic [CHAR_W-1:0] ch);
    int gap;
    in_valid_r  <= 1'b1;
    in_action_r <= act;
    in_char_r   <= ch;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_r <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic stop_stream();
    in_valid_r <= 1'b0;
  endtask

  // every verdict back, then a little slack for the output register
  task automatic wait_idle();
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle; pready is tied high
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, {RIDX_LSB{1'b0}}};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // push the whole kw_* set into the block; only called while idle
  task automatic apply_config();
    write_reg(REG_NAME_COUNT, PDATA_W'(kw_count));
    for (int i = 0; i < NUM_NAMES; i++)
      write_reg(reg_idx_t'(int'(REG_NAME_WORD_0) + i), PDATA_W'(kw_word[i]));
    write_reg(REG_NAME_LENGTHS, PDATA_W'({kw_len[3], kw_len[2], kw_len[1], kw_len[0]}));
    write_reg(REG_MATCH_KIND, PDATA_W'(kw_kind));
    settings_applied++;
  endtask

  // mostly from a small alphabet so keywords actually get hit
  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 7) == 0) return CHAR_W'($urandom);
    return alphabet[$urandom_range(0, ALPHA_SIZE-1)];
  endfunction

  function automatic int usable_len(int k);
    int l;
    l = int'(kw_len[k]);
    if (l > MAX_NAME_LEN) l = MAX_NAME_LEN;
    return l;
  endfunction

  // Random keyword set. Later keywords often share a prefix with an earlier one so
  // elimination is gradual; sometimes a full duplicate. Odd lengths (zero,
  // beyond four) and odd counts (zero, above four) show up too.
  task automatic build_random_config(input int p);
    int src;
    int keep;
    case (p)
      0: kw_count = 3'd1;
      1: kw_count = 3'd4;
      2: kw_count = 3'd0;
      3: kw_count = 3'd7;
      4: kw_count = 3'd2;
      5: kw_count = 3'd3;
      6: kw_count = 3'd5;
      default: kw_count = 3'd4;
    endcase
    if (p == 0) kw_kind = '0;
    else if (p == RANDOM_PHASES - 1) kw_kind = '1;
    else kw_kind = KIND_W'($urandom);
    for (int a = 0; a < ALPHA_SIZE; a++) alphabet[a] = CHAR_W'($urandom);
    alphabet[0] = (p % 2) ? 16'hFFFF : 16'h0000;
    for (int j = 0; j < CHARS_PER_WORD; j++) kw_word[0][CHAR_W*j +: CHAR_W] = pick_char();
    for (int i = 1; i < NUM_NAMES; i++) begin
      src  = $urandom_range(0, i - 1);
      keep = $urandom_range(0, 4);
      for (int j = 0; j < CHARS_PER_WORD; j++)
        kw_word[i][CHAR_W*j +: CHAR_W] =
          (j < keep) ? kw_word[src][CHAR_W*j +: CHAR_W] : pick_char();
    end
    for (int i = 0; i < NUM_NAMES; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: kw_len[i] = 3'd0;
          1: kw_len[i] = 3'd5;
          2: kw_len[i] = 3'd6;
          default: kw_len[i] = 3'd7;
        endcase
      end else begin
        kw_len[i] = LEN_W'($urandom_range(1, 4));
      end
    end
  endtask

  // Mostly: restart, spell one keyword (maybe cut short or with one wrong
  // character), then a few trailing characters. Rest is raw noise.
  task automatic run_sequence();
    int k;
    int len;
    int bad_at;
    int tail;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 4))
        send_beat(($urandom_range(0, 3) == 0) ? ACT_RESTART : ACT_FEED, CHAR_W'($urandom));
    end else begin
      send_beat(ACT_RESTART, CHAR_W'($urandom));
      k   = $urandom_range(0, NUM_NAMES - 1);
      len = usable_len(k);
      if (len == 0) len = $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
      bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : -1;
      for (int j = 0; j < len; j++)
        send_beat(ACT_FEED, (j == bad_at) ? pick_char() : kw_word[k][CHAR_W*j +: CHAR_W]);
      tail = $urandom_range(0, 3);
      repeat (tail) send_beat(ACT_FEED, pick_char());
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    int total_fail;

    // synchronous reset, held low from the start and released at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default registers: single keyword of length zero, so a feed is bad
    send_beat(ACT_FEED, 16'h0000);
    stop_stream();
    wait_idle();

    // directed set: shared prefixes, all-ones and all-zeros characters,
    // a one-character keyword, top kind value
    kw_count   = 3'd4;
    kw_word[0] = {16'h0044, 16'h0043, 16'h0042, 16'h0041};
    kw_word[1] = {16'h0000, 16'h0058, 16'h0042, 16'h0041};
    kw_word[2] = '1;
    kw_word[3] = '0;
    kw_len[0]  = 3'd4;
    kw_len[1]  = 3'd3;
    kw_len[2]  = 3'd2;
    kw_len[3]  = 3'd1;
    kw_kind    = '1;
    apply_config();
    // full 4-char word: pending, then recognized, then bad
    send_beat(ACT_RESTART, 16'hFFFF);
    send_beat(ACT_FEED, 16'h0041);
    send_beat(ACT_FEED, 16'h0042);
    send_beat(ACT_FEED, 16'h0043);
    send_beat(ACT_FEED, 16'h0044);
    send_beat(ACT_FEED, 16'h0020);
    send_beat(ACT_FEED, 16'h0020);
    // split off at third char onto the 3-char keyword
    send_beat(ACT_RESTART, 16'h0000);
    send_beat(ACT_FEED, 16'h0041);
    send_beat(ACT_FEED, 16'h0042);
    send_beat(ACT_FEED, 16'h0058);
    send_beat(ACT_FEED, 16'h8001);
    // all-ones keyword
    send_beat(ACT_RESTART, 16'h0000);
    send_beat(ACT_FEED, 16'hFFFF);
    send_beat(ACT_FEED, 16'hFFFF);
    send_beat(ACT_FEED, 16'h0000);
    // one-char keyword goes pending on its first character
    send_beat(ACT_RESTART, 16'h0000);
    send_beat(ACT_FEED, 16'h0000);
    send_beat(ACT_FEED, 16'h5555);
    // no candidate at all: failed, and stays bad
    send_beat(ACT_RESTART, 16'h0000);
    send_beat(ACT_FEED, 16'h1234);
    send_beat(ACT_FEED, 16'h0041);
    stop_stream();
    wait_idle();

    // count above four saturates, a zero length, lengths past four saturate,
    // identical complete candidates stay checking and then all drop out
    kw_count   = 3'd7;
    kw_word[0] = '1;
    kw_word[1] = '1;
    kw_word[2] = '1;
    kw_word[3] = '1;
    kw_len[0]  = 3'd0;
    kw_len[1]  = 3'd7;
    kw_len[2]  = 3'd6;
    kw_len[3]  = 3'd5;
    kw_kind    = '0;
    apply_config();
    send_beat(ACT_RESTART, 16'h0000);
    repeat (5) send_beat(ACT_FEED, 16'hFFFF);
    stop_stream();
    wait_idle();

    // random phases, each under a fresh register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      build_random_config(p);
      apply_config();
      target = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < target) run_sequence();
      stop_stream();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    total_fail = chk_errors + chk_pending;
    $display("Run covered %0d character beats under %0d register settings,", beats_sent,
             settings_applied);
    $display("with %0d keywords recognized along the way.", chk_matches);
    if (total_fail == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog: far above the slowest legal run (~550 beats with long gaps and
  // stalls, plus register writes, is well under 40 us)
  initial begin
    #300us;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kem_pkg.sv
sv/kem_if.sv
sv/kem_regs.sv
sv/keyword_elimination_matcher_unit.sv
tb/sv/kem_verdict_checker.sv
tb/sv/tb_keyword_elimination_matcher_unit.sv
